### design/buddy_pkg.sv
// Shared constants for the binary buddy allocator.
`default_nettype none

package buddy_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W = 32;
  localparam int REQ_W  = 23;
  localparam int LG_W   = 4;
  localparam int ABLK_W = 11;
  localparam int PADDR_W = 4;

  // Request codes carried on the mode field.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ARENA_BASE   = 2'd0;
  localparam logic [1:0] REG_MIN_BLOCK_LG = 2'd1;
  localparam logic [1:0] REG_ARENA_BLOCKS = 2'd2;

endpackage

`default_nettype wire

### design/buddy_allocator_top.sv
// Top level of the binary buddy allocator: control sequencer and state memories.
`default_nettype none

// Channel   | Direction | Handshake              | Beat contents
// ----------+-----------+------------------------+-------------------------------------
// in_       | input     | in_valid / in_stall    | mode, request_bytes, block_address
// out_      | output    | out_valid / out_stall  | user_address, granted
// APB       | input     | psel, penable, pready  | arena_base, min_block_log2, arena_blocks
//
// One request is worked on at a time. An allocate first finds the fitting tier (one
// tier a cycle), then scans the free map one node a cycle through its single read port,
// from the fitting tier upwards, and then splits the found node down to that tier.
// A free that is taken reads the live store and clears the live mark, then for each
// merge step reads and checks the buddy; it ends by marking the merged node free.
// A rejected free ends without touching the free map. The scan over the free map
// sets the latency of an allocate. After reset, and after a write of min_block_log2 or
// arena_blocks, a clearing pass over all 2*MAX_BLOCKS-1 nodes rewrites the free map
// with the initial carving and clears the live marks; in_stall is high during it.
// A finished result waits while out_stall holds an earlier one in the output register.
module buddy_allocator_top
  import buddy_pkg::*;
#(
  parameter int MAX_BLOCKS   = 1024,
  parameter int TIER_COUNT   = 11,
  parameter int HEADER_BYTES = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_mode,
  input  wire  [REQ_W-1:0]     in_request_bytes,
  input  wire  [ADDR_W-1:0]    in_block_address,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [ADDR_W-1:0]    out_user_address,
  output logic                 out_granted,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [PADDR_W-1:0]   paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Width of a node index within one tier; BW is the width of block counts.
  localparam int LW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LOG_MAX = $clog2(MAX_BLOCKS);
  localparam int BW = LOG_MAX + 1;
  // The free map holds every tier of the binary tree: 2*MAX_BLOCKS-1 nodes.
  localparam int MAP_DEPTH = 2 * MAX_BLOCKS - 1;
  localparam int AW = LOG_MAX + 1;
  localparam int MAXT = (TIER_COUNT > LOG_MAX + 1) ? TIER_COUNT : LOG_MAX + 1;
  localparam int TW = $clog2(MAXT + 2);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FIT, S_SCAN, S_SPLIT, S_FLIVE, S_MRD, S_MCK, S_RESP
  } state_t;

  // Memory address of node i at tier t: tiers are stacked from the smallest blocks up.
  function automatic logic [AW-1:0] node_addr(input logic [TW-1:0] t, input logic [LW-1:0] i);
    int b;
    b = 2 * MAX_BLOCKS - ((2 * MAX_BLOCKS) >> t);
    return AW'(b + int'(i));
  endfunction

  function automatic logic [LW-1:0] last_idx(input logic [TW-1:0] t);
    int v;
    v = (MAX_BLOCKS >> t) - 1;
    return LW'(v);
  endfunction

  // Whether node i of tier t is free in the greedy carving of n blocks.
  function automatic logic carve(input logic [TW-1:0] t, input logic [LW-1:0] i,
                                 input logic [BW-1:0] n, input logic [TW-1:0] top,
                                 input logic nz);
    int nn;
    int ii;
    nn = int'(n);
    ii = int'(i);
    if (!nz) return 1'b0;
    if (t == top) return ii < (nn >> t);
    if (t < top) return (((nn >> t) & 1) == 1) && (ii == ((nn >> (t + 1)) << 1));
    return 1'b0;
  endfunction

  // Configuration registers.
  logic [ADDR_W-1:0] arena_base_r;
  logic [LG_W-1:0]   min_lg_r;
  logic [ABLK_W-1:0] arena_blocks_r;

  // Control registers.
  state_t            state_r, state_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [TW-1:0]     sw_t_r, sw_t_nxt;
  logic [LW-1:0]     sw_i_r, sw_i_nxt;
  logic              mode_r, mode_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [TW-1:0]     t_req_r, t_req_nxt;
  logic [TW-1:0]     s_r, s_nxt;
  logic [LW-1:0]     i_r, i_nxt;
  logic              pv_r, pv_nxt;
  logic [TW-1:0]     ps_r, ps_nxt;
  logic [LW-1:0]     pi_r, pi_nxt;
  logic [TW-1:0]     cur_s_r, cur_s_nxt;
  logic [LW-1:0]     cur_i_r, cur_i_nxt;
  logic [LW-1:0]     blk_r, blk_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              res_gnt_r, res_gnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_gnt_r, out_gnt_nxt;

  // Memory ports.
  logic              fm_mem [MAP_DEPTH];
  logic              fm_we;
  logic [AW-1:0]     fm_wa;
  logic              fm_wd;
  logic [AW-1:0]     fm_ra;
  logic              fm_rd_r;
  logic [TW:0]       lv_mem [MAX_BLOCKS];
  logic              lv_we;
  logic [LW-1:0]     lv_wa;
  logic [TW:0]       lv_wd;
  logic [LW-1:0]     lv_ra;
  logic [TW:0]       lv_rd_r;

  // Derived arena geometry.
  logic [BW-1:0]     n_w;
  logic              nz_w;
  logic [TW-1:0]     top_w;

  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic [32:0]       size_w;
  logic [32:0]       need_w;
  logic [ADDR_W-1:0] rel_w;
  logic [ADDR_W-1:0] mask_w;
  logic [ADDR_W-1:0] blk32_w;
  logic [LW-1:0]     alloc_blk_w;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_ARENA_BASE:   prdata = arena_base_r;
      REG_MIN_BLOCK_LG: prdata = 32'(min_lg_r);
      REG_ARENA_BLOCKS: prdata = 32'(arena_blocks_r);
      default:          prdata = '0;
    endcase
  end

  // An arena longer than the memory is clipped; the top tier is the largest that fits.
  always_comb begin
    if (32'(arena_blocks_r) > 32'(MAX_BLOCKS)) begin
      n_w = BW'(MAX_BLOCKS);
    end else begin
      n_w = BW'(arena_blocks_r);
    end
    nz_w  = (n_w != '0);
    top_w = '0;
    for (int t = 0; t < TIER_COUNT; t++) begin
      if ((33'(1) << t) <= 33'(n_w)) top_w = TW'(t);
    end
  end

  // A tier serves a request when its block size covers the request plus the header.
  assign size_w  = 33'(1) << (6'(min_lg_r) + 6'(s_r));
  assign need_w  = 33'(req_r) + 33'(HEADER_BYTES);
  assign rel_w   = addr_r - arena_base_r - ADDR_W'(HEADER_BYTES);
  assign mask_w  = (ADDR_W'(1) << min_lg_r) - ADDR_W'(1);
  assign blk32_w = rel_w >> min_lg_r;
  assign alloc_blk_w = cur_i_r << t_req_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    sw_t_nxt      = sw_t_r;
    sw_i_nxt      = sw_i_r;
    mode_nxt      = mode_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    t_req_nxt     = t_req_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    pv_nxt        = 1'b0;
    ps_nxt        = ps_r;
    pi_nxt        = pi_r;
    cur_s_nxt     = cur_s_r;
    cur_i_nxt     = cur_i_r;
    blk_nxt       = blk_r;
    res_addr_nxt  = res_addr_r;
    res_gnt_nxt   = res_gnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_addr_nxt  = out_addr_r;
    out_gnt_nxt   = out_gnt_r;
    fm_we = 1'b0;
    fm_wa = '0;
    fm_wd = 1'b0;
    fm_ra = '0;
    lv_we = 1'b0;
    lv_wa = '0;
    lv_wd = '0;
    lv_ra = '0;

    case (state_r)
      S_CLEAR: begin
        fm_we = 1'b1;
        fm_wa = k_r;
        fm_wd = carve(sw_t_r, sw_i_r, n_w, top_w, nz_w);
        if (32'(k_r) < 32'(MAX_BLOCKS)) begin
          lv_we = 1'b1;
          lv_wa = k_r[LW-1:0];
          lv_wd = '0;
        end
        if (32'(k_r) == 32'(MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + AW'(1);
          if (sw_i_r == last_idx(sw_t_r)) begin
            sw_t_nxt = sw_t_r + TW'(1);
            sw_i_nxt = '0;
          end else begin
            sw_i_nxt = sw_i_r + LW'(1);
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          req_nxt   = in_request_bytes;
          addr_nxt  = in_block_address;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_addr_nxt = '0;
        res_gnt_nxt  = 1'b0;
        if (mode_r == MODE_ALLOC) begin
          s_nxt     = '0;
          state_nxt = nz_w ? S_FIT : S_RESP;
        end else if (((rel_w & mask_w) != '0) || (blk32_w >= 32'(n_w))) begin
          state_nxt = S_RESP;
        end else begin
          lv_ra     = blk32_w[LW-1:0];
          blk_nxt   = blk32_w[LW-1:0];
          state_nxt = S_FLIVE;
        end
      end
      S_FIT: begin
        if (s_r > top_w) begin
          state_nxt = S_RESP;
        end else if (size_w >= need_w) begin
          t_req_nxt = s_r;
          i_nxt     = '0;
          state_nxt = S_SCAN;
        end else begin
          s_nxt = s_r + TW'(1);
        end
      end
      S_SCAN: begin
        // Reads stream one node a cycle; the node read last cycle is checked now.
        if (pv_r && fm_rd_r) begin
          fm_we     = 1'b1;
          fm_wa     = node_addr(ps_r, pi_r);
          fm_wd     = 1'b0;
          cur_s_nxt = ps_r;
          cur_i_nxt = pi_r;
          state_nxt = S_SPLIT;
        end else if (s_r > top_w) begin
          if (!pv_r) state_nxt = S_RESP;
        end else begin
          fm_ra  = node_addr(s_r, i_r);
          pv_nxt = 1'b1;
          ps_nxt = s_r;
          pi_nxt = i_r;
          if (i_r == last_idx(s_r)) begin
            s_nxt = s_r + TW'(1);
            i_nxt = '0;
          end else begin
            i_nxt = i_r + LW'(1);
          end
        end
      end
      S_SPLIT: begin
        if (cur_s_r == t_req_r) begin
          lv_we        = 1'b1;
          lv_wa        = alloc_blk_w;
          lv_wd        = {1'b1, t_req_r};
          res_addr_nxt = arena_base_r + (ADDR_W'(alloc_blk_w) << min_lg_r)
                         + ADDR_W'(HEADER_BYTES);
          res_gnt_nxt  = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          // Keep the lower half and release the upper half one tier down.
          fm_we     = 1'b1;
          fm_wa     = node_addr(cur_s_r - TW'(1), {cur_i_r[LW-2:0], 1'b1});
          fm_wd     = 1'b1;
          cur_s_nxt = cur_s_r - TW'(1);
          cur_i_nxt = cur_i_r << 1;
        end
      end
      S_FLIVE: begin
        if (!lv_rd_r[TW]) begin
          state_nxt = S_RESP;
        end else begin
          lv_we     = 1'b1;
          lv_wa     = blk_r;
          lv_wd     = {1'b0, lv_rd_r[TW-1:0]};
          cur_s_nxt = lv_rd_r[TW-1:0];
          cur_i_nxt = blk_r >> lv_rd_r[TW-1:0];
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        if (cur_s_r < top_w) begin
          fm_ra     = node_addr(cur_s_r, cur_i_r ^ LW'(1));
          state_nxt = S_MCK;
        end else begin
          fm_we       = 1'b1;
          fm_wa       = node_addr(cur_s_r, cur_i_r);
          fm_wd       = 1'b1;
          res_gnt_nxt = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_MCK: begin
        fm_we = 1'b1;
        if (fm_rd_r) begin
          // The buddy is free: take it out and climb to the parent.
          fm_wa     = node_addr(cur_s_r, cur_i_r ^ LW'(1));
          fm_wd     = 1'b0;
          cur_i_nxt = cur_i_r >> 1;
          cur_s_nxt = cur_s_r + TW'(1);
          state_nxt = S_MRD;
        end else begin
          fm_wa       = node_addr(cur_s_r, cur_i_r);
          fm_wd       = 1'b1;
          res_gnt_nxt = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_gnt_nxt   = res_gnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A change of geometry rebuilds the store from the carving.
    if (cfg_wr && ((cfg_idx == REG_MIN_BLOCK_LG) || (cfg_idx == REG_ARENA_BLOCKS))) begin
      state_nxt = S_CLEAR;
      k_nxt     = '0;
      sw_t_nxt  = '0;
      sw_i_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      k_r            <= '0;
      sw_t_r         <= '0;
      sw_i_r         <= '0;
      pv_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      arena_base_r   <= '0;
      min_lg_r       <= LG_W'(5);
      arena_blocks_r <= ABLK_W'(1024);
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      sw_t_r      <= sw_t_nxt;
      sw_i_r      <= sw_i_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ARENA_BASE:   arena_base_r   <= pwdata;
          REG_MIN_BLOCK_LG: min_lg_r       <= pwdata[LG_W-1:0];
          REG_ARENA_BLOCKS: arena_blocks_r <= pwdata[ABLK_W-1:0];
          default: ;
        endcase
      end
    end
    mode_r     <= mode_nxt;
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    t_req_r    <= t_req_nxt;
    s_r        <= s_nxt;
    i_r        <= i_nxt;
    ps_r       <= ps_nxt;
    pi_r       <= pi_nxt;
    cur_s_r    <= cur_s_nxt;
    cur_i_r    <= cur_i_nxt;
    blk_r      <= blk_nxt;
    res_addr_r <= res_addr_nxt;
    res_gnt_r  <= res_gnt_nxt;
    out_addr_r <= out_addr_nxt;
    out_gnt_r  <= out_gnt_nxt;
  end

  // Free map: one bit per tree node.
  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    fm_rd_r <= fm_mem[fm_ra];
  end

  // Live store: live mark and tier at the first block of each allocation.
  always_ff @(posedge clk) begin
    if (lv_we) lv_mem[lv_wa] <= lv_wd;
    lv_rd_r <= lv_mem[lv_ra];
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_user_address = out_addr_r;
  assign out_granted      = out_gnt_r;

endmodule

`default_nettype wire
